/* design/fdlr_pkg.sv */
// ----------------------------------------------------------------------------
// fdlr_pkg
// Shared constants, types and helpers of the frame dirty line range core.
// ----------------------------------------------------------------------------
package fdlr_pkg;

  localparam int unsigned LINE_W       = 9;
  localparam int unsigned PIX_W        = 16;
  localparam int unsigned FRAME_PIXELS = 76800;
  localparam int unsigned MAX_LINE     = 320;
  localparam int unsigned ADDR_W       = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int unsigned PROD_W       = 2 * LINE_W;
  localparam int unsigned CMP_W        = ((PROD_W > ADDR_W) ? PROD_W : ADDR_W) + 1;

  localparam logic [LINE_W-1:0] WIDTH_RESET = LINE_W'(320);
  localparam logic [LINE_W-1:0] COUNT_RESET = LINE_W'(240);

  localparam logic REG_LINE_WIDTH = 1'b0;
  localparam logic REG_LINE_COUNT = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [ADDR_W-1:0] addr;
    logic              in_range;
    logic [LINE_W-1:0] line;
    logic              frame_end;
  } fdlr_item_t;

  function automatic logic [LINE_W-1:0] clamp_reg(input logic [LINE_W-1:0] value);
    logic [LINE_W-1:0] v;
    v = value;
    if (v == '0) begin
      v = LINE_W'(1);
    end
    if (v > LINE_W'(MAX_LINE)) begin
      v = LINE_W'(MAX_LINE);
    end
    return v;
  endfunction

endpackage

/* design/frame_dirty_line_range_core.sv */
// ----------------------------------------------------------------------------
// frame_dirty_line_range_core
// Compares each pixel with the stored previous frame and reports the range
// of changed lines once per frame.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o  pixel_i
//   out      output     out_valid_o / out_stall_i first_line_o, end_line_o,
//                                                changed_o
//   cfg      input      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// One pixel per clock while in_stall_o is low; a frame result is registered
// after its last pixel passes the request and stage-two registers. Pipeline:
// address multiply, store read, compare and write back.
// After reset the store is cleared one entry per cycle, all 76800 entries, with
// in_stall_o high. out_stall_i holds the pipeline only while a finished
// result is still pending and the next frame's last pixel reaches the end.
// ----------------------------------------------------------------------------
module frame_dirty_line_range_core
  import fdlr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [LINE_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [PIX_W-1:0]  pixel_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [LINE_W-1:0] first_line_o,
  output logic [LINE_W-1:0] end_line_o,
  output logic              changed_o
);

  logic              clr_q;
  logic [ADDR_W-1:0] clr_addr_q;
  logic              adv, accept, retire;
  logic              s1_valid, s2_valid_q;
  fdlr_item_t        s1_item, s2_item_q;
  logic [LINE_W-1:0] line_count;
  logic [PIX_W-1:0]  rdata, prev_pixel, fwd_pix_q;
  logic              fwd_hit_q;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [PIX_W-1:0]  ram_wdata;

  assign adv        = !(s2_valid_q && s2_item_q.frame_end && out_valid_o && out_stall_i);
  assign in_stall_o = clr_q || !adv;
  assign accept     = in_valid_i && !in_stall_o;
  assign retire     = adv && s2_valid_q;

  fdlr_raster_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (accept),
    .adv_i        (adv),
    .pixel_i      (pixel_i),
    .item_valid_o (s1_valid),
    .item_o       (s1_item),
    .line_count_o (line_count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      s2_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + ADDR_W'(1);
        if (clr_addr_q == ADDR_W'(FRAME_PIXELS - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (adv) begin
        s2_valid_q <= s1_valid;
        fwd_hit_q  <= retire && s2_item_q.in_range && (s2_item_q.addr == s1_item.addr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_item_q <= s1_item;
      fwd_pix_q <= s2_item_q.pixel;
    end
  end

  // write port: clearing pass first, then write-back of retiring pixels
  assign ram_we    = clr_q || (retire && s2_item_q.in_range);
  assign ram_waddr = clr_q ? clr_addr_q : s2_item_q.addr;
  assign ram_wdata = clr_q ? '0 : s2_item_q.pixel;

  fdlr_frame_ram u_ram (
    .clk_i   (clk_i),
    .re_i    (adv),
    .raddr_i (s1_item.addr),
    .rdata_o (rdata),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata)
  );

  assign prev_pixel = fwd_hit_q ? fwd_pix_q : rdata;

  fdlr_dirty_track u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .retire_i     (retire),
    .item_i       (s2_item_q),
    .prev_pixel_i (prev_pixel),
    .line_count_i (line_count),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .first_line_o (first_line_o),
    .end_line_o   (end_line_o),
    .changed_o    (changed_o)
  );

endmodule

/* design/fdlr_frame_ram.sv */
// ----------------------------------------------------------------------------
// fdlr_frame_ram
// Frame store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fdlr_frame_ram
  import fdlr_pkg::*;
(
  input  logic              clk_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [PIX_W-1:0]  rdata_o,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [PIX_W-1:0]  wdata_i
);

  logic [PIX_W-1:0] mem [FRAME_PIXELS];
  logic [PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/fdlr_raster_seq.sv */
// ----------------------------------------------------------------------------
// fdlr_raster_seq
// Config registers, column/line counters and store address of each request.
// ----------------------------------------------------------------------------
module fdlr_raster_seq
  import fdlr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [LINE_W-1:0] cfg_wdata_i,
  input  logic              accept_i,
  input  logic              adv_i,
  input  logic [PIX_W-1:0]  pixel_i,
  output logic              item_valid_o,
  output fdlr_item_t        item_o,
  output logic [LINE_W-1:0] line_count_o
);

  logic [LINE_W-1:0] width_q, count_q, col_q, line_q;
  logic [LINE_W:0]   col_p1, line_p1;
  logic              line_end, frame_end;
  logic [PROD_W-1:0] prod;
  logic [CMP_W-1:0]  sum;
  logic              valid_q;
  fdlr_item_t        item_q;

  assign col_p1    = {1'b0, col_q} + (LINE_W+1)'(1);
  assign line_p1   = {1'b0, line_q} + (LINE_W+1)'(1);
  assign line_end  = col_p1 >= {1'b0, width_q};
  assign frame_end = line_end && (line_p1 >= {1'b0, count_q});
  assign prod      = PROD_W'(line_q) * PROD_W'(width_q);
  assign sum       = CMP_W'(prod) + CMP_W'(col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RESET;
      count_q <= COUNT_RESET;
      col_q   <= '0;
      line_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LINE_WIDTH: width_q <= clamp_reg(cfg_wdata_i);
          REG_LINE_COUNT: count_q <= clamp_reg(cfg_wdata_i);
          default: ;
        endcase
      end
      if (accept_i) begin
        col_q <= line_end ? '0 : col_p1[LINE_W-1:0];
        if (line_end) begin
          line_q <= frame_end ? '0 : line_p1[LINE_W-1:0];
        end
      end
      if (adv_i) begin
        valid_q <= accept_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q.pixel     <= pixel_i;
      item_q.addr      <= sum[ADDR_W-1:0];
      item_q.in_range  <= sum < CMP_W'(FRAME_PIXELS);
      item_q.line      <= line_q;
      item_q.frame_end <= frame_end;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;
  assign line_count_o = count_q;

endmodule

/* design/fdlr_dirty_track.sv */
// ----------------------------------------------------------------------------
// fdlr_dirty_track
// Pixel compare, first/last changed line tracking and the result register.
// ----------------------------------------------------------------------------
module fdlr_dirty_track
  import fdlr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              retire_i,
  input  fdlr_item_t        item_i,
  input  logic [PIX_W-1:0]  prev_pixel_i,
  input  logic [LINE_W-1:0] line_count_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [LINE_W-1:0] first_line_o,
  output logic [LINE_W-1:0] end_line_o,
  output logic              changed_o
);

  logic              any_q;
  logic [LINE_W-1:0] first_q, last_q;
  logic              diff, any_n;
  logic [LINE_W-1:0] first_n, last_n;
  logic              out_valid_q;
  logic [LINE_W-1:0] first_line_q, end_line_q;
  logic              changed_q;

  assign diff    = item_i.in_range && (prev_pixel_i != item_i.pixel);
  assign any_n   = any_q | diff;
  assign first_n = (diff && !any_q) ? item_i.line : first_q;
  assign last_n  = diff ? item_i.line : last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q       <= 1'b0;
      first_q     <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (retire_i) begin
        if (item_i.frame_end) begin
          any_q       <= 1'b0;
          first_q     <= '0;
          last_q      <= '0;
          out_valid_q <= 1'b1;
        end else begin
          any_q   <= any_n;
          first_q <= first_n;
          last_q  <= last_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (retire_i && item_i.frame_end) begin
      first_line_q <= any_n ? first_n : line_count_i;
      end_line_q   <= any_n ? (last_n + LINE_W'(1)) : line_count_i;
      changed_q    <= any_n;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign first_line_o = first_line_q;
  assign end_line_o   = end_line_q;
  assign changed_o    = changed_q;

endmodule

/* test/frame_dirty_line_range_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_dirty_line_range_core_tb
// Self-checking bench for the changed-line range core. A tracker class keeps
// its own copy of the frame store, counters and geometry, predicts the range
// of every finished frame and checks each result against the oldest one.
// Directed frames come first, then frames with random content and geometry,
// a mid-frame geometry change that runs past the store, and a long output
// hold-off that backs up the input.
// ----------------------------------------------------------------------------
module frame_dirty_line_range_core_tb;
  import fdlr_pkg::*;

  localparam int unsigned RESET_CYCLES    = 9;
  localparam int unsigned DRAIN_CYCLES    = 12;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned RANDOM_PIXELS   = 550;
  localparam int unsigned CYCLE_LIMIT     = 400000;

  typedef struct packed {
    logic [LINE_W-1:0] first_line;
    logic [LINE_W-1:0] end_line;
    logic              changed;
  } line_range_t;

  class line_range_tracker;
    logic [PIX_W-1:0] frame_store [FRAME_PIXELS];
    int unsigned      width;
    int unsigned      count;
    int unsigned      col;
    int unsigned      line;
    int unsigned      first_diff;
    int unsigned      last_diff;
    bit               any_diff;
    line_range_t      pending_ranges[$];
    int unsigned      errors;

    function new();
      foreach (frame_store[i]) frame_store[i] = '0;
      width      = 320;
      count      = 240;
      col        = 0;
      line       = 0;
      first_diff = 0;
      last_diff  = 0;
      any_diff   = 1'b0;
      errors     = 0;
    endfunction

    function int unsigned limit_reg(logic [LINE_W-1:0] value);
      if (value == '0) return 1;
      if (value > MAX_LINE) return MAX_LINE;
      return 32'(value);
    endfunction

    function void write_reg(logic idx, logic [LINE_W-1:0] value);
      if (idx == REG_LINE_WIDTH) begin
        width = limit_reg(value);
      end else begin
        count = limit_reg(value);
      end
    endfunction

    function logic [PIX_W-1:0] stored_here();
      int unsigned addr;
      addr = line * width + col;
      if (addr < FRAME_PIXELS) return frame_store[addr];
      return PIX_W'($urandom());
    endfunction

    function void note_pixel(logic [PIX_W-1:0] px);
      int unsigned addr;
      line_range_t r;
      addr = line * width + col;
      if (addr < FRAME_PIXELS) begin
        if (frame_store[addr] != px) begin
          if (!any_diff) first_diff = line;
          last_diff = line;
          any_diff  = 1'b1;
        end
        frame_store[addr] = px;
      end
      if (col + 1 < width) begin
        col = (col + 1) & 'h1FF;
        return;
      end
      col = 0;
      if (line + 1 < count) begin
        line = (line + 1) & 'h1FF;
        return;
      end
      if (any_diff) begin
        r.first_line = LINE_W'(first_diff);
        r.end_line   = LINE_W'(last_diff + 1);
        r.changed    = 1'b1;
      end else begin
        r.first_line = LINE_W'(count);
        r.end_line   = LINE_W'(count);
        r.changed    = 1'b0;
      end
      pending_ranges.push_back(r);
      line       = 0;
      first_diff = 0;
      last_diff  = 0;
      any_diff   = 1'b0;
    endfunction

    function void check_range(logic [LINE_W-1:0] first_line, logic [LINE_W-1:0] end_line,
                              logic changed);
      line_range_t want;
      if (pending_ranges.size() == 0) begin
        $error("unexpected frame result: first_line %0d end_line %0d changed %0b",
               first_line, end_line, changed);
        errors++;
        return;
      end
      want = pending_ranges.pop_front();
      if (first_line !== want.first_line) begin
        $error("first_line: expected %0d, got %0d", want.first_line, first_line);
        errors++;
      end
      if (end_line !== want.end_line) begin
        $error("end_line: expected %0d, got %0d", want.end_line, end_line);
        errors++;
      end
      if (changed !== want.changed) begin
        $error("changed: expected %0b, got %0b", want.changed, changed);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic              cfg_idx_i   = REG_LINE_WIDTH;
  logic [LINE_W-1:0] cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [PIX_W-1:0]  pixel_i     = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [LINE_W-1:0] first_line_o;
  logic [LINE_W-1:0] end_line_o;
  logic              changed_o;

  line_range_tracker tracker = new();
  int unsigned       pixels_sent = 0;
  int unsigned       cycle_count = 0;
  bit                tx_calm = 1'b0;
  bit                rx_calm = 1'b0;
  bit                hold_off_req = 1'b0;

  frame_dirty_line_range_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_i     (pixel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .first_line_o(first_line_o),
    .end_line_o  (end_line_o),
    .changed_o   (changed_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // output side: random stalls, calm stretches, one long hold-off on request
  always begin
    @(posedge clk_i);
    if (hold_off_req) begin
      out_stall_i <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      hold_off_req = 1'b0;
      out_stall_i <= 1'b0;
    end else if (rx_calm) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 26);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_range(first_line_o, end_line_o, changed_o);
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] px);
    int unsigned gap;
    gap = 0;
    if (!tx_calm) begin
      while ($urandom_range(0, 99) < 26) gap++;
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i    <= px;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_pixel(px);
    pixels_sent++;
  endtask

  // wait until every frame result is in and the pipeline has drained
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_ranges.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [LINE_W-1:0] width_raw,
                              input logic [LINE_W-1:0] count_raw);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_LINE_WIDTH;
    cfg_wdata_i <= width_raw;
    @(posedge clk_i);
    tracker.write_reg(REG_LINE_WIDTH, width_raw);
    cfg_idx_i   <= REG_LINE_COUNT;
    cfg_wdata_i <= count_raw;
    @(posedge clk_i);
    tracker.write_reg(REG_LINE_COUNT, count_raw);
    cfg_we_i <= 1'b0;
  endtask

  // unchanged pixels most often, some single-bit changes, some random
  function automatic logic [PIX_W-1:0] pick_pixel();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return tracker.stored_here();
    if (r < 70) return tracker.stored_here() ^ (PIX_W'(1) << $urandom_range(0, PIX_W - 1));
    return PIX_W'($urandom());
  endfunction

  task automatic random_phase();
    logic [LINE_W-1:0] w_raw;
    logic [LINE_W-1:0] c_raw;
    int unsigned       n;
    w_raw = LINE_W'($urandom_range(1, 4));
    c_raw = LINE_W'($urandom_range(1, 4));
    case ($urandom_range(0, 9))
      0: w_raw = '0;
      1: c_raw = '0;
      2: w_raw = LINE_W'($urandom_range(5, 24));
      3: c_raw = LINE_W'($urandom_range(5, 12));
      default: ;
    endcase
    set_geometry(w_raw, c_raw);
    // often stops mid-frame, so the next geometry lands on running counters
    n = $urandom_range(1, 3 * tracker.width * tracker.count);
    repeat (n) send_pixel(pick_pixel());
    settle();
  endtask

  initial begin
    int unsigned random_start;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);

    // 1x1 frames: every pixel closes a frame on address zero
    set_geometry('0, '0);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'hFFFF);
    send_pixel(16'h5A5A);
    send_pixel(16'hA5A5);
    send_pixel(16'h0000);
    settle();

    // only change in column zero of the last line, then an unchanged frame
    set_geometry(9'd2, 9'd3);
    repeat (2) begin
      send_pixel(16'h0000);
      send_pixel(16'h0000);
      send_pixel(16'h0000);
      send_pixel(16'h0000);
      send_pixel(16'hA5A5);
      send_pixel(16'h0000);
    end
    settle();

    set_geometry(9'd4, 9'd1);
    send_pixel(16'h0001);
    send_pixel(16'h0002);
    send_pixel(16'h0003);
    send_pixel(16'h0004);
    settle();

    random_start = pixels_sent;

    // 1x320 frame, widened past the store at line 240, then narrowed again
    set_geometry('0, 9'd511);
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    repeat (240) send_pixel(pick_pixel());
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    settle();
    set_geometry(9'd320, 9'd511);
    repeat (2) send_pixel(pick_pixel());
    settle();
    set_geometry(9'd1, 9'd320);
    repeat (79) send_pixel(pick_pixel());
    send_pixel(~tracker.stored_here());
    settle();

    random_phase();
    random_phase();

    // long output hold-off with back-to-back 1x1 frames fills the pipeline
    set_geometry(9'd1, 9'd1);
    tx_calm      = 1'b1;
    hold_off_req = 1'b1;
    repeat (40) send_pixel(pick_pixel());
    tx_calm = 1'b0;
    settle();

    while (pixels_sent < random_start + RANDOM_PIXELS) random_phase();

    settle();
    if (tracker.errors == 0 && tracker.pending_ranges.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
